// ===== hw/rtl/qmop_pkg.sv =====
// Shared types, constants and helpers for the quadratic map orbit plotter.
// No dependencies.
package qmop_pkg;

  localparam int unsigned FrameWidthDef  = 256;
  localparam int unsigned FrameHeightDef = 256;
  localparam logic [31:0] EscapeLimitDef = 32'd1073741824;

  localparam logic signed [31:0] CoefAReset      = -32'sd18454938;
  localparam logic signed [31:0] CoefBReset      = 32'sd28856812;
  localparam logic [7:0]         SettleReset     = 8'd48;
  localparam logic [6:0]         DrawReset       = 7'd20;
  localparam logic signed [31:0] ViewLeftReset   = -32'sd29360128;
  localparam logic signed [31:0] ViewBottomReset = -32'sd29360128;
  localparam logic [30:0]        ScaleReset      = 31'd1227133513;
  localparam logic [6:0]         MaxDraw         = 7'd64;

  typedef enum logic [2:0] {
    REG_COEF_A      = 3'd0,
    REG_COEF_B      = 3'd1,
    REG_SETTLE      = 3'd2,
    REG_DRAW        = 3'd3,
    REG_VIEW_LEFT   = 3'd4,
    REG_VIEW_BOTTOM = 3'd5,
    REG_X_SCALE     = 3'd6,
    REG_Y_SCALE     = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SUM, ST_PLOT, ST_EMIT
  } state_t;

  // Datapath operation selected by the controller for its current state.
  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD, OP_MUL, OP_SUM, OP_PLOT
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic escape;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Q8.24 product, floor shift by 24, saturated.
  function automatic logic signed [31:0] qmul_sat(input logic signed [63:0] p);
    logic signed [39:0] q;
    q = p[63:24];
    if (q > 40'sd2147483647) return 32'sh7fffffff;
    if (q < -40'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

endpackage

// ===== hw/rtl/qmop_if.sv =====
// Valid/ready channel interface for seed and result items.
// Generic over payload type; no other dependencies.
interface qmop_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/qmop_ctrl.sv =====
// Controller state machine: sequences settle and draw iterations, emits items.
// Depends on qmop_pkg.
module qmop_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_escaped,
  output logic                   out_last,
  input  logic [7:0]             settle_count,
  input  logic [6:0]             draw_count,
  output qmop_pkg::dp_cmd_t      cmd,
  input  qmop_pkg::dp_status_t   status
);
  import qmop_pkg::*;

  state_t     state, state_next;
  logic       drawing;
  logic [7:0] step;
  logic [6:0] draws;
  logic       esc_flag;
  logic       last_flag;

  always_comb begin
    if (draw_count == 7'd0) draws = 7'd1;
    else if (draw_count > MaxDraw) draws = MaxDraw;
    else draws = draw_count;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = (settle_count == 8'd0) ? ST_MUL : ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM: begin
        if (status.escape) state_next = ST_EMIT;
        else if (drawing) state_next = ST_PLOT;
        else if (step + 8'd1 == settle_count) state_next = ST_MUL;
        else state_next = ST_MUL;
      end
      ST_PLOT: state_next = ST_EMIT;
      ST_EMIT: if (out_ready) state_next = (esc_flag || last_flag) ? ST_IDLE : ST_MUL;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_EMIT);
    out_escaped = esc_flag;
    out_last    = esc_flag || last_flag;
    unique case (state)
      ST_IDLE: cmd.op = in_valid ? OP_LOAD : OP_NONE;
      ST_MUL:  cmd.op = OP_MUL;
      ST_SUM:  cmd.op = OP_SUM;
      ST_PLOT: cmd.op = OP_PLOT;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      drawing <= 1'b0;
      step <= 8'd0;
      esc_flag <= 1'b0;
      last_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_valid) begin
        drawing   <= (settle_count == 8'd0);
        step      <= 8'd0;
        esc_flag  <= 1'b0;
        last_flag <= 1'b0;
      end else if (state == ST_SUM) begin
        if (status.escape) esc_flag <= 1'b1;
        else if (drawing) begin
          last_flag <= (step + 8'd1 == {1'b0, draws});
          step <= step + 8'd1;
        end else if (step + 8'd1 == settle_count) begin
          drawing <= 1'b1;
          step <= 8'd0;
        end else step <= step + 8'd1;
      end
    end
  end
endmodule

// ===== hw/rtl/qmop_dp.sv =====
// Datapath: orbit registers, four registered products, saturating sums, pixel map.
// Depends on qmop_pkg.
module qmop_dp #(
  parameter int unsigned FRAME_WIDTH  = qmop_pkg::FrameWidthDef,
  parameter int unsigned FRAME_HEIGHT = qmop_pkg::FrameHeightDef,
  parameter logic [31:0] ESCAPE_LIMIT = qmop_pkg::EscapeLimitDef
) (
  input  logic                  clk,
  input  qmop_pkg::dp_cmd_t     cmd,
  output qmop_pkg::dp_status_t  status,
  input  logic signed [31:0]    seed_x,
  input  logic signed [31:0]    seed_y,
  input  logic signed [31:0]    coef_a,
  input  logic signed [31:0]    coef_b,
  input  logic signed [31:0]    view_left,
  input  logic signed [31:0]    view_bottom,
  input  logic [30:0]           x_scale,
  input  logic [30:0]           y_scale,
  output logic [7:0]            pixel_x,
  output logic [7:0]            pixel_y,
  output logic                  on_screen
);
  import qmop_pkg::*;

  localparam logic signed [63:0] One   = 64'sd1 <<< 48;
  localparam logic signed [63:0] WLim  = 64'(FRAME_WIDTH) <<< 48;
  localparam logic signed [63:0] HOne  = 64'(FRAME_HEIGHT) <<< 48;
  localparam logic signed [63:0] HLim  = 64'(FRAME_HEIGHT + 1) <<< 48;

  logic signed [31:0] ox, oy;
  logic signed [31:0] pax, pyy, pby, pxy;
  logic signed [31:0] nx, ny;
  logic signed [32:0] dx, dy;
  logic signed [63:0] pu, pv, r;
  logic               okx, oky;

  always_comb begin
    nx = sat32(34'(pax) - 34'(pyy));
    ny = sat32(34'(pby) + 34'(pxy));
    status.escape = (nx > $signed(ESCAPE_LIMIT)) || (nx < -$signed(ESCAPE_LIMIT)) ||
                    (ny > $signed(ESCAPE_LIMIT)) || (ny < -$signed(ESCAPE_LIMIT));
    dx = 33'(ox) - 33'(view_left);
    dy = 33'(oy) - 33'(view_bottom);
    pu = 64'(dx) * $signed({33'd0, x_scale});
    pv = 64'(dy) * $signed({33'd0, y_scale});
    okx = (pu > -One) && (pu < WLim);
    oky = (pv > 64'sd0) && (pv < HLim);
    r = HOne - pv;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        ox <= seed_x;
        oy <= seed_y;
      end
      OP_MUL: begin
        pax <= qmul_sat(64'(coef_a) * 64'(ox));
        pyy <= qmul_sat(64'(oy) * 64'(oy));
        pby <= qmul_sat(64'(coef_b) * 64'(oy));
        pxy <= qmul_sat(64'(ox) * 64'(oy));
      end
      OP_SUM: begin
        ox <= nx;
        oy <= ny;
      end
      OP_PLOT: begin
        on_screen <= okx && oky;
        pixel_x <= (okx && oky && pu >= 0) ? pu[55:48] : 8'd0;
        pixel_y <= (okx && oky && r >= 0) ? r[55:48] : 8'd0;
      end
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/quadratic_map_orbit_plotter_core.sv =====
// Top level of the quadratic map orbit plotter: config registers, controller, datapath.
// Depends on qmop_pkg, qmop_if, qmop_ctrl, qmop_dp.
//
//  channel  | dir | payload
//  seed     | in  | seed_x, seed_y (signed Q8.24)
//  result   | out | pixel_x, pixel_y, on_screen, escaped, last
//  config   | in  | cfg_we, cfg_idx, cfg_data
//
// Each map iteration runs a product state (four product registers), then a sum and escape
// check state; each drawn point adds a plot state and an emit state. One seed at a time.
// Reset is synchronous; a stalled result holds the controller in its emit state.
module quadratic_map_orbit_plotter_core #(
  parameter int unsigned FRAME_WIDTH  = qmop_pkg::FrameWidthDef,
  parameter int unsigned FRAME_HEIGHT = qmop_pkg::FrameHeightDef,
  parameter logic [31:0] ESCAPE_LIMIT = qmop_pkg::EscapeLimitDef
) (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [2:0]  cfg_idx,
  input logic [31:0] cfg_data,
  qmop_if.sink       seed,
  qmop_if.source     result
);
  import qmop_pkg::*;

  logic signed [31:0] coef_a, coef_b, view_left, view_bottom;
  logic [7:0]  settle_count;
  logic [6:0]  draw_count;
  logic [30:0] x_scale, y_scale;
  dp_cmd_t     cmd;
  dp_status_t  status;
  logic        escaped, last;
  logic [7:0]  pixel_x, pixel_y;
  logic        on_screen;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= CoefAReset;
      coef_b <= CoefBReset;
      settle_count <= SettleReset;
      draw_count <= DrawReset;
      view_left <= ViewLeftReset;
      view_bottom <= ViewBottomReset;
      x_scale <= ScaleReset;
      y_scale <= ScaleReset;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_COEF_A:      coef_a <= cfg_data;
        REG_COEF_B:      coef_b <= cfg_data;
        REG_SETTLE:      settle_count <= cfg_data[7:0];
        REG_DRAW:        draw_count <= cfg_data[6:0];
        REG_VIEW_LEFT:   view_left <= cfg_data;
        REG_VIEW_BOTTOM: view_bottom <= cfg_data;
        REG_X_SCALE:     x_scale <= cfg_data[30:0];
        REG_Y_SCALE:     y_scale <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  qmop_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(seed.valid), .in_ready(seed.ready),
    .out_valid(result.valid), .out_ready(result.ready),
    .out_escaped(escaped), .out_last(last),
    .settle_count, .draw_count, .cmd, .status
  );

  qmop_dp #(
    .FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT), .ESCAPE_LIMIT(ESCAPE_LIMIT)
  ) u_dp (
    .clk, .cmd, .status,
    .seed_x(seed.data.seed_x), .seed_y(seed.data.seed_y),
    .coef_a, .coef_b, .view_left, .view_bottom, .x_scale, .y_scale,
    .pixel_x, .pixel_y, .on_screen
  );

  always_comb begin
    result.data.pixel_x   = escaped ? 8'd0 : pixel_x;
    result.data.pixel_y   = escaped ? 8'd0 : pixel_y;
    result.data.on_screen = escaped ? 1'b0 : on_screen;
    result.data.escaped   = escaped;
    result.data.last      = last;
  end
endmodule
